@@ rtl/gradient_noise_4d_top_macros.svh @@
// Assertion macros for the gradient noise block
`ifndef GRADIENT_NOISE_4D_TOP_MACROS_SVH
`define GRADIENT_NOISE_4D_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define GN_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GN_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GN_ASSERT(label, clk, rst_n, prop, msg)
`define GN_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/gn4d_pkg.sv @@
// Shared types and constants for the gradient noise block
`default_nettype none
package gn4d_pkg;
	localparam int IDX_W = 8;
	localparam logic [7:0] IDX_MASK = 8'hff;
	localparam logic [4:0] GRAD_MASK = 5'h1f;
	localparam int FADE_C6 = 6;
	localparam int FADE_C15 = 15;
	localparam int FADE_C10 = 10;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SPLIT, ST_FADE_T2, ST_FADE_T3, ST_FADE_OUT, ST_CORNER_RD,
		ST_CORNER_WT, ST_CORNER_DOT, ST_LERP_MUL, ST_LERP_ADD, ST_OUT
	} gn4d_state_t;

	typedef enum logic [1:0] {
		MS_T2, MS_T3, MS_FADE, MS_LERP
	} gn4d_mul_sel_t;

	typedef struct packed {
		logic          load_coords;
		logic          split;
		logic          mul_go;
		gn4d_mul_sel_t mul_sel;
		logic          fade_store;
		logic [1:0]    axis;
		logic          rd_go;
		logic [1:0]    rd_level;
		logic [3:0]    corner;
		logic          dot_store;
		logic [3:0]    lerp_idx;
		logic          lerp_store;
		logic          out_load;
	} gn4d_cmd_t;

	// component of gradient g for axis a: 1 pos, 2 neg, 0 zero
	function automatic logic [1:0] grad_comp(input logic [4:0] g, input logic [1:0] a);
		logic [1:0] p;
		logic       neg;
		logic [1:0] r;
		p = g[1:0];
		neg = 1'b0;
		r = 2'd0;
		// zero column: p==0 -> w, 1 -> z, 2 -> y, 3 -> x
		if ((2'd3 - a) != p) begin
			// sign bits: first nonzero uses g[4], second g[3], third g[2]
			case (p) inside
				2'd0, 2'd1: neg = (a == 2'd0) ? g[4] : (a == 2'd1) ? g[3] : g[2];
				2'd2: neg = (a == 2'd0) ? g[4] : (a == 2'd2) ? g[3] : g[2];
				default: neg = (a == 2'd1) ? g[4] : (a == 2'd2) ? g[3] : g[2];
			endcase
			r = neg ? 2'd2 : 2'd1;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/gn4d_ctrl.sv @@
// Sequencer for the gradient noise block
`default_nettype none
module gn4d_ctrl
	import gn4d_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_kind,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	output gn4d_cmd_t      cmd
);
	gn4d_state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic [3:0] corner_q, corner_d;
	logic [1:0] lvl_q, lvl_d;
	logic [3:0] li_q, li_d;
	logic       ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			corner_q <= '0;
			lvl_q <= '0;
			li_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
			corner_q <= corner_d;
			lvl_q <= lvl_d;
			li_q <= li_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		corner_d = corner_q;
		lvl_d = lvl_q;
		li_d = li_q;
		ov_d = ov_q && out_stall;
		cmd = '0;
		cmd.axis = axis_q;
		cmd.corner = corner_q;
		cmd.rd_level = lvl_q;
		cmd.lerp_idx = li_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && in_kind) begin
					cmd.load_coords = 1'b1;
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				axis_d = '0;
				state_d = ST_FADE_T2;
			end
			ST_FADE_T2: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = MS_T2;
				state_d = ST_FADE_T3;
			end
			ST_FADE_T3: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = MS_T3;
				state_d = ST_FADE_OUT;
			end
			ST_FADE_OUT: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = MS_FADE;
				cmd.fade_store = 1'b1;
				axis_d = axis_q + 2'd1;
				if (axis_q == 2'd3) begin
					corner_d = '0;
					lvl_d = '0;
					state_d = ST_CORNER_RD;
				end else begin
					state_d = ST_FADE_T2;
				end
			end
			ST_CORNER_RD: begin
				cmd.rd_go = 1'b1;
				state_d = ST_CORNER_WT;
			end
			ST_CORNER_WT: begin
				lvl_d = lvl_q + 2'd1;
				state_d = (lvl_q == 2'd3) ? ST_CORNER_DOT : ST_CORNER_RD;
			end
			ST_CORNER_DOT: begin
				cmd.dot_store = 1'b1;
				corner_d = corner_q + 4'd1;
				if (corner_q == 4'd15) begin
					li_d = '0;
					state_d = ST_LERP_MUL;
				end else begin
					state_d = ST_CORNER_RD;
				end
			end
			ST_LERP_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = MS_LERP;
				state_d = ST_LERP_ADD;
			end
			ST_LERP_ADD: begin
				cmd.lerp_store = 1'b1;
				li_d = li_q + 4'd1;
				state_d = (li_q == 4'd14) ? ST_OUT : ST_LERP_MUL;
			end
			ST_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/gn4d_datapath.sv @@
// Datapath: coordinate split, fade and lerp multiplier, table and corner dot
`default_nettype none
module gn4d_datapath
	import gn4d_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        tbl_we,
	input  wire logic [7:0]  tbl_idx,
	input  wire logic [7:0]  tbl_val,
	input  wire logic [31:0] cx,
	input  wire logic [31:0] cy,
	input  wire logic [31:0] cz,
	input  wire logic [31:0] cw,
	input  gn4d_cmd_t        cmd,
	output logic [18:0]      noise_value
);
	localparam int FW = FRAC_BITS + 2;     // fraction / fade width, signed
	localparam int VW = FRAC_BITS + 6;     // corner / lerp value width
	localparam int MW = FRAC_BITS + 8;     // multiplier operand width
	localparam int PW = 2 * MW;            // product width
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] OMAX = 64'sd262143;
	localparam logic signed [63:0] OMIN = -64'sd262144;

	logic [7:0] perm_mem [TABLE_ENTRIES];
	logic [7:0] rd_data_q;
	logic [7:0] rd_addr;

	logic signed [31:0] coord_q [4];
	logic [7:0]         cell_q [4];
	logic signed [FW-1:0] frac_q [4];
	logic signed [FW-1:0] fade_q [4];
	logic signed [FW-1:0] t2_q, t3_q;
	logic signed [VW-1:0] v_q [16];
	logic signed [VW-1:0] prod_q;
	logic [7:0] h_q;
	logic signed [18:0] out_q;

	// table port
	always_comb begin
		logic [7:0] base;
		case (cmd.rd_level)
			2'd0: base = cell_q[0] + {7'd0, cmd.corner[3]};
			2'd1: base = cell_q[1] + {7'd0, cmd.corner[2]};
			2'd2: base = cell_q[2] + {7'd0, cmd.corner[1]};
			default: base = cell_q[3] + {7'd0, cmd.corner[0]};
		endcase
		rd_addr = (cmd.rd_level == 2'd0) ? base : ((base + h_q) & IDX_MASK);
	end

	always_ff @(posedge clk) begin
		if (tbl_we) perm_mem[tbl_idx] <= tbl_val;
		rd_data_q <= perm_mem[rd_addr];
	end

	// h chain register loads the returned byte from the registered read data after each read
	logic rd_pend_s1;
	always_ff @(posedge clk) begin
		rd_pend_s1 <= cmd.rd_go;
		if (rd_pend_s1) h_q <= rd_data_q;
	end

	// coordinate split
	always_ff @(posedge clk) begin
		if (cmd.load_coords) begin
			coord_q[0] <= cx; coord_q[1] <= cy; coord_q[2] <= cz; coord_q[3] <= cw;
		end
		if (cmd.split) begin
			for (int a = 0; a < 4; a++) begin
				logic signed [32:0] v;
				logic signed [32:0] k;
				logic signed [33:0] f;
				if (coord_q[a] > 0) begin
					k = {1'b0, coord_q[a]} >>> FRAC_BITS;
				end else begin
					v = {coord_q[a][31], coord_q[a]} - 33'(ONE);
					if (v < -33'sd2147483648) v = -33'sd2147483648;
					k = -((-v) >>> FRAC_BITS);
				end
				f = 34'(coord_q[a]) - (34'(k) <<< FRAC_BITS);
				cell_q[a] <= k[7:0];
				frac_q[a] <= f[FW-1:0];
			end
		end
	end

	// shared multiplier
	logic signed [VW-1:0] lerp_a, lerp_b;
	logic signed [FW-1:0] lerp_s;
	always_comb begin
		lerp_a = v_q[0]; lerp_b = v_q[1]; lerp_s = fade_q[3];
		case (cmd.lerp_idx) inside
			[4'd0:4'd7]: begin
				lerp_a = v_q[{cmd.lerp_idx[2:0], 1'b0}];
				lerp_b = v_q[{cmd.lerp_idx[2:0], 1'b1}];
				lerp_s = fade_q[3];
			end
			[4'd8:4'd11]: begin
				lerp_a = v_q[{1'b0, cmd.lerp_idx[1:0], 1'b0}];
				lerp_b = v_q[{1'b0, cmd.lerp_idx[1:0], 1'b1}];
				lerp_s = fade_q[2];
			end
			[4'd12:4'd13]: begin
				lerp_a = v_q[{2'b0, cmd.lerp_idx[0], 1'b0}];
				lerp_b = v_q[{2'b0, cmd.lerp_idx[0], 1'b1}];
				lerp_s = fade_q[1];
			end
			default: begin
				lerp_a = v_q[0]; lerp_b = v_q[1]; lerp_s = fade_q[0];
			end
		endcase
	end

	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] mprod, mr;
	always_comb begin
		logic signed [MW-1:0] t;
		t = MW'(frac_q[cmd.axis]);
		case (cmd.mul_sel)
			MS_T2: begin ma = t; mb = t; end
			MS_T3: begin ma = MW'(t2_q); mb = t; end
			MS_FADE: begin
				ma = MW'(t3_q);
				mb = MW'(FADE_C6) * MW'(t2_q) - MW'(FADE_C15) * t
					+ MW'(FADE_C10) * MW'(ONE);
			end
			default: begin ma = MW'(lerp_b) - MW'(lerp_a); mb = MW'(lerp_s); end
		endcase
		mprod = ma * mb;
		mr = (mprod + PW'(HALF)) >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go && cmd.mul_sel == MS_T2) t2_q <= mr[FW-1:0];
		if (cmd.mul_go && cmd.mul_sel == MS_T3) t3_q <= mr[FW-1:0];
		if (cmd.fade_store) fade_q[cmd.axis] <= mr[FW-1:0];
		if (cmd.mul_go && cmd.mul_sel == MS_LERP) prod_q <= mr[VW-1:0];
	end

	// corner dot and lerp writeback
	always_ff @(posedge clk) begin
		if (cmd.dot_store) begin
			logic signed [VW-1:0] sum;
			logic [4:0] g;
			logic signed [VW-1:0] off;
			logic [1:0] gc;
			g = h_q[4:0] & GRAD_MASK;
			sum = '0;
			for (int a = 0; a < 4; a++) begin
				off = VW'(frac_q[a]);
				if (cmd.corner[3-a]) off = off - VW'(ONE);
				gc = grad_comp(g, 2'(a));
				if (gc == 2'd1) sum = sum + off;
				else if (gc == 2'd2) sum = sum - off;
			end
			v_q[cmd.corner] <= sum;
		end
		if (cmd.lerp_store) begin
			case (cmd.lerp_idx) inside
				[4'd0:4'd7]:
					v_q[{1'b0, cmd.lerp_idx[2:0]}] <= lerp_a + prod_q;
				[4'd8:4'd11]:
					v_q[{2'b0, cmd.lerp_idx[1:0]}] <= lerp_a + prod_q;
				[4'd12:4'd13]:
					v_q[{3'b0, cmd.lerp_idx[0]}] <= lerp_a + prod_q;
				default: v_q[0] <= lerp_a + prod_q;
			endcase
		end
		if (cmd.out_load) begin
			if (64'(v_q[0]) > OMAX) out_q <= 19'(OMAX);
			else if (64'(v_q[0]) < OMIN) out_q <= 19'(OMIN);
			else out_q <= v_q[0][18:0];
		end
	end

	assign noise_value = out_q;
endmodule
`default_nettype wire

@@ rtl/gradient_noise_4d_top.sv @@
// Top level of the 4-D gradient noise block
// An evaluate beat is taken only while the sequencer is idle; its result is
// registered after these steps in order: the split, three fade multiplies per
// axis, then for each of the 16 corners four chained reads on the single table
// port (each a read step and a wait step) and a dot step, then 15 lerps on the
// shared multiplier (each a multiply step and an add step) and the result load.
// The next beat is taken the cycle after, so an evaluation is done before the
// next one is taken; a load beat only writes the table. A stalled result sits in
// the result register; a later evaluation waits at its last step until it frees.
`default_nettype none
`include "gradient_noise_4d_top_macros.svh"
module gradient_noise_4d_top
	import gn4d_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  table_index,
	input  wire logic [7:0]  table_value,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	input  wire logic signed [31:0] coord_w,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [18:0] noise_value
);
	gn4d_cmd_t cmd;

	gn4d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_kind(kind),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
	);

	gn4d_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .tbl_we(in_valid && !in_stall && !kind),
		.tbl_idx(table_index), .tbl_val(table_value),
		.cx(coord_x), .cy(coord_y), .cz(coord_z), .cw(coord_w),
		.cmd(cmd), .noise_value(noise_value)
	);

	`GN_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(noise_value), "result dropped while stalled")
	`GN_ASSERT(a_busy_stall, clk, arst_n, cmd.rd_go |-> in_stall, "input taken during table walk")
	`GN_ASSERT(a_eval_start, clk, arst_n, in_valid && !in_stall && kind |=> in_stall, "evaluate did not start")
endmodule
`default_nettype wire

@@ tb/gradient_noise_4d_top_tb.sv @@
// Testbench for the 4-D gradient noise block: table loads, evaluations, self-predicted results
`default_nettype none
module gradient_noise_4d_top_tb
	import gn4d_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam longint HALF = 64'sd1 << (FRAC - 1);
	localparam longint NOISE_MAX = 262143;
	localparam longint NOISE_MIN = -262144;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [7:0] table_index = '0;
	logic [7:0] table_value = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic signed [31:0] coord_z = '0;
	logic signed [31:0] coord_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [18:0] noise_value;

	gradient_noise_4d_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .table_index(table_index), .table_value(table_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .coord_w(coord_w),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	always #2 clk = ~clk;

	logic [7:0] perm_copy [256];
	logic signed [18:0] noise_queue [$];
	int errors = 0;
	int cycles = 0;
	int evals_sent = 0;
	int loads_sent = 0;
	int noise_seen = 0;
	int stall_left = 0;
	bit sender_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;

	// gradient table, 32 x 4 components, packed as -1/0/1
	function automatic int grad_comp_of(int g, int a);
		int t [32][4] = '{
			'{1,1,1,0}, '{1,1,0,1}, '{1,0,1,1}, '{0,1,1,1},
			'{1,1,-1,0}, '{1,1,0,-1}, '{1,0,1,-1}, '{0,1,1,-1},
			'{1,-1,1,0}, '{1,-1,0,1}, '{1,0,-1,1}, '{0,1,-1,1},
			'{1,-1,-1,0}, '{1,-1,0,-1}, '{1,0,-1,-1}, '{0,1,-1,-1},
			'{-1,1,1,0}, '{-1,1,0,1}, '{-1,0,1,1}, '{0,-1,1,1},
			'{-1,1,-1,0}, '{-1,1,0,-1}, '{-1,0,1,-1}, '{0,-1,1,-1},
			'{-1,-1,1,0}, '{-1,-1,0,1}, '{-1,0,-1,1}, '{0,-1,-1,1},
			'{-1,-1,-1,0}, '{-1,-1,0,-1}, '{-1,0,-1,-1}, '{0,-1,-1,-1}};
		return t[g][a];
	endfunction

	// rounded fixed product, ties toward +inf (>>> floors)
	function automatic longint fmul(longint a, longint b);
		return (a * b + HALF) >>> FRAC;
	endfunction

	function automatic longint fade_curve(longint t);
		longint t2, t3;
		t2 = fmul(t, t);
		t3 = fmul(t2, t);
		return fmul(t3, 6 * t2 - 15 * t + 10 * ONE);
	endfunction

	function automatic logic signed [18:0] noise_at(logic signed [31:0] c [4]);
		longint cube [4], frac [4], sm [4], v [16], sum, cv, vv, off;
		int g, bit_a, n;
		logic [7:0] h, ix;
		for (int a = 0; a < 4; a++) begin
			cv = c[a];
			if (cv > 0) begin
				cube[a] = cv >>> FRAC;
			end else begin
				vv = cv - ONE;
				if (vv < -64'sd2147483648) vv = -64'sd2147483648;
				cube[a] = -((-vv) >>> FRAC);
			end
			frac[a] = cv - cube[a] * ONE;
			sm[a] = fade_curve(frac[a]);
		end
		for (int k = 0; k < 16; k++) begin
			h = 8'd0;
			for (int a = 0; a < 4; a++) begin
				bit_a = (k >> (3 - a)) & 1;
				ix = 8'(cube[a] + bit_a);
				h = perm_copy[8'(ix + h)];
			end
			g = h & GRAD_MASK;
			sum = 0;
			for (int a = 0; a < 4; a++) begin
				off = ((k >> (3 - a)) & 1) ? frac[a] - ONE : frac[a];
				sum += grad_comp_of(g, a) * off;
			end
			v[k] = sum;
		end
		n = 16;
		for (int a = 3; a >= 0; a--) begin
			n >>= 1;
			for (int i = 0; i < n; i++) v[i] = v[2*i] + fmul(v[2*i+1] - v[2*i], sm[a]);
		end
		if (v[0] > NOISE_MAX) v[0] = NOISE_MAX;
		if (v[0] < NOISE_MIN) v[0] = NOISE_MIN;
		return 19'(v[0]);
	endfunction

	task automatic sender_gap();
		int n;
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one beat; valid stays high after acceptance so the next beat can follow directly
	task automatic send_beat(logic k, logic [7:0] idx, logic [7:0] val,
			logic signed [31:0] c [4]);
		sender_gap();
		in_valid <= 1'b1;
		kind <= k;
		table_index <= idx;
		table_value <= val;
		coord_x <= c[0];
		coord_y <= c[1];
		coord_z <= c[2];
		coord_w <= c[3];
		if (k == KIND_LOAD) begin
			perm_copy[idx] = val;
			loads_sent++;
		end else begin
			noise_queue.push_back(noise_at(c));
			evals_sent++;
		end
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_entry(logic [7:0] idx, logic [7:0] val);
		logic signed [31:0] c [4];
		foreach (c[a]) c[a] = $urandom;
		send_beat(KIND_LOAD, idx, val, c);
	endtask

	task automatic eval_point(logic signed [31:0] c [4]);
		send_beat(KIND_EVAL, 8'($urandom), 8'($urandom), c);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 20)) << FRAC;
			2: return -(32'($urandom_range(0, 20)) << FRAC);
			default: return 32'(int'($urandom_range(0, 32'h01ff_ffff)) - 32'h00ff_ffff);
		endcase
	endfunction

	task automatic test_table_fill();
		for (int i = 0; i < 256; i++) load_entry(8'(i), 8'($urandom));
	endtask

	task automatic test_directed_points();
		logic signed [31:0] pts [12] = '{32'sh0, 32'sh1_0000, -32'sh1_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0001, 32'sh0000_8000, -32'sh0000_8000, 32'sh1,
			-32'sh1, 32'sh00ff_ffff, 32'sh0100_0000};
		logic signed [31:0] c [4];
		for (int i = 0; i < 12; i++) begin
			foreach (c[a]) c[a] = pts[(i + a * 5) % 12];
			eval_point(c);
		end
		foreach (c[a]) c[a] = 32'sh8000_0000;
		eval_point(c);
		foreach (c[a]) c[a] = 32'sh7fff_ffff;
		eval_point(c);
	endtask

	// wait out everything in flight before rewriting the table
	task automatic test_drain_and_reload();
		in_valid <= 1'b0;
		while (noise_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		for (int i = 0; i < 256; i++) load_entry(8'(i), (i % 2) ? 8'hff : 8'h00);
	endtask

	task automatic test_random_mix(int count);
		logic signed [31:0] c [4];
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				load_entry(8'($urandom), 8'($urandom));
			end else begin
				foreach (c[a]) c[a] = rand_coord();
				eval_point(c);
			end
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			noise_seen++;
			if (noise_queue.size() == 0) begin
				$display("%0t: unexpected noise beat, actual %0d", $realtime, noise_value);
				errors++;
			end else begin
				if (noise_queue[0] !== noise_value) begin
					$display("%0t: noise_value expected %0d actual %0d", $realtime,
						noise_queue[0], noise_value);
					errors++;
				end
				void'(noise_queue.pop_front());
			end
		end
		// receiver stalls come in bursts, counted down in stall_left
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed_points();
		test_drain_and_reload();
		test_directed_points();
		test_drain_and_reload();
		test_table_fill();
		test_random_mix(600);
		sender_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		test_random_mix(150);
		in_valid <= 1'b0;
		while (noise_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d table writes and %0d evaluations, %0d results checked.",
			loads_sent, evals_sent, noise_seen);
		if (errors == 0 && noise_queue.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/gn4d_pkg.sv
rtl/gn4d_ctrl.sv
rtl/gn4d_datapath.sv
rtl/gradient_noise_4d_top.sv
tb/gradient_noise_4d_top_tb.sv
